/* hw/rtl/wpq_pkg.sv */
// shared constants, codes and types of the weight priority queue
`default_nettype none

package wpq_pkg;

    // queue geometry and field widths
    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 16;
    localparam int WEIGHT_W    = 8;
    localparam int STATUS_W    = 3;

    // weight limit after reset
    localparam logic [WEIGHT_W-1:0] LIMIT_RESET = WEIGHT_W'(30);

    // command codes
    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_DUMP   = 1'b1
    } t_opcode;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_REJECTED = 3'd2,
        ST_ENTRY    = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    // one stored entry
    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [WEIGHT_W-1:0] weight;
    } t_entry;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic   insert;
        logic   rotate;
        t_entry new_entry;
    } t_chain_ctrl;

    // status returned by the chain
    typedef struct packed {
        logic   full;
        t_entry head;
    } t_chain_stat;

endpackage

`default_nettype wire

/* hw/rtl/wpq_if.sv */
// handshake channels of the weight priority queue: commands, results, configuration
`default_nettype none

interface wpq_in_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [wpq_pkg::ID_W-1:0]     entry_id;
    logic [wpq_pkg::WEIGHT_W-1:0] entry_weight;

    modport source (output valid, output opcode, output entry_id, output entry_weight,
                    input ready);
    modport sink   (input valid, input opcode, input entry_id, input entry_weight,
                    output ready);
endinterface

interface wpq_out_if;
    logic                         valid;
    logic                         ready;
    logic [wpq_pkg::STATUS_W-1:0] status;
    logic [wpq_pkg::ID_W-1:0]     out_id;
    logic [wpq_pkg::WEIGHT_W-1:0] out_weight;
    logic                         last;

    modport source (output valid, output status, output out_id, output out_weight,
                    output last, input ready);
    modport sink   (input valid, input status, input out_id, input out_weight,
                    input last, output ready);
endinterface

interface wpq_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [wpq_pkg::WEIGHT_W-1:0] weight_limit;

    modport source (output valid, output weight_limit, input ready);
    modport sink   (input valid, input weight_limit, output ready);
endinterface

`default_nettype wire

/* hw/rtl/wpq_cell.sv */
// one slot of the sorted chain: holds an entry and trades it with its neighbours
`default_nettype none

module wpq_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire wpq_pkg::t_chain_ctrl i_ctrl,
    input  wire wpq_pkg::t_entry i_prev,
    input  wire                  i_prev_valid,
    input  wire                  i_prev_ge,
    input  wire wpq_pkg::t_entry i_next,
    input  wire                  i_next_valid,
    input  wire wpq_pkg::t_entry i_head,
    output wpq_pkg::t_entry      o_entry,
    output logic                 o_valid,
    output logic                 o_ge
);

    logic            r_valid;
    logic            n_valid;
    wpq_pkg::t_entry r_entry;
    wpq_pkg::t_entry n_entry;

    // new item belongs at or before this slot
    assign o_ge = !r_valid || (r_entry.weight < i_ctrl.new_entry.weight);

    // insert shifts the tail down by one, rotate cycles the occupied slots
    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_ctrl.insert) begin
            n_valid = r_valid || i_prev_valid;
            if (i_prev_ge) begin
                n_entry = i_prev;
            end else if (o_ge) begin
                n_entry = i_ctrl.new_entry;
            end
        end else if (i_ctrl.rotate) begin
            n_entry = i_next_valid ? i_next : i_head;
        end
    end

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // stored entry
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

/* hw/rtl/wpq_chain.sv */
// row of queue cells kept sorted by weight, highest at the head
`default_nettype none

module wpq_chain (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire wpq_pkg::t_chain_ctrl i_ctrl,
    output wpq_pkg::t_chain_stat o_stat
);

    localparam int D = wpq_pkg::QUEUE_DEPTH;

    wpq_pkg::t_entry w_entry [D];
    logic [D-1:0]    w_valid;
    logic [D-1:0]    w_ge;

    genvar g;
    generate
        for (g = 0; g < D; g++) begin : g_cell
            wpq_pkg::t_entry w_prev;
            logic            w_prev_valid;
            logic            w_prev_ge;
            wpq_pkg::t_entry w_next;
            logic            w_next_valid;

            // head cell sees an always-full, never-displaced neighbour before it
            if (g == 0) begin : g_first
                assign w_prev       = i_ctrl.new_entry;
                assign w_prev_valid = 1'b1;
                assign w_prev_ge    = 1'b0;
            end else begin : g_mid
                assign w_prev       = w_entry[g-1];
                assign w_prev_valid = w_valid[g-1];
                assign w_prev_ge    = w_ge[g-1];
            end

            // tail cell has nothing behind it
            if (g == D - 1) begin : g_last
                assign w_next       = w_entry[0];
                assign w_next_valid = 1'b0;
            end else begin : g_inner
                assign w_next       = w_entry[g+1];
                assign w_next_valid = w_valid[g+1];
            end

            wpq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (i_ctrl),
                .i_prev       (w_prev),
                .i_prev_valid (w_prev_valid),
                .i_prev_ge    (w_prev_ge),
                .i_next       (w_next),
                .i_next_valid (w_next_valid),
                .i_head       (w_entry[0]),
                .o_entry      (w_entry[g]),
                .o_valid      (w_valid[g]),
                .o_ge         (w_ge[g])
            );
        end
    endgenerate

    assign o_stat.full = w_valid[D-1];
    assign o_stat.head = w_entry[0];

endmodule

`default_nettype wire

/* hw/rtl/weight_priority_queue_core.sv */
// top level of the weight priority queue: command sequencer, result register, cell chain
//
// Usage
//   i_in carries commands: opcode insert with entry_id and entry_weight, or dump.
//   o_out carries results: status, out_id, out_weight and last.
//   i_cfg writes the weight limit at any time the block is idle; it is always ready.
//   An insert heavier than the limit gives status rejected, one into a full
//   queue gives status full, otherwise the entry joins the sorted chain.
//   Every insert gives one item, in the cycle after acceptance, with last set.
//   A dump gives one item per stored entry, heaviest first, equal weights in
//   arrival order, the first out of the dump state, then one per cycle while the
//   receiver keeps up; last marks the final one. An empty queue gives one empty item.
//   A dump rotates the occupied cells once round, so the queue is unchanged.
//   Throughput: one insert per cycle while the receiver keeps up; a dump of n entries
//   holds the command channel while the chain head yields them, one per unstalled cycle.
//   Reset empties the queue and sets the limit to 30; no clearing pass.
//   When the receiver stalls, the result register holds and the sequencer waits.
`default_nettype none

module weight_priority_queue_core (
    input  wire      i_clk,
    input  wire      i_rst_n,
    wpq_in_if.sink   i_in,
    wpq_out_if.source o_out,
    wpq_cfg_if.sink  i_cfg
);

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } t_state;

    t_state                            r_state;
    logic [wpq_pkg::CNT_W-1:0]         r_count;
    logic [wpq_pkg::CNT_W-1:0]         r_left;
    logic [wpq_pkg::WEIGHT_W-1:0]      r_limit;
    logic                              r_out_valid;
    wpq_pkg::t_status                  r_out_status;
    logic [wpq_pkg::ID_W-1:0]          r_out_id;
    logic [wpq_pkg::WEIGHT_W-1:0]      r_out_weight;
    logic                              r_out_last;

    wpq_pkg::t_chain_ctrl              w_ctrl;
    wpq_pkg::t_chain_stat              w_stat;
    logic                              w_slot_free;
    logic                              w_in_fire;
    logic                              w_is_insert;
    logic                              w_heavy;

    // handshake and command decode
    assign w_slot_free = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && w_slot_free;
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign w_is_insert = (i_in.opcode == wpq_pkg::OP_INSERT);
    assign w_heavy     = i_in.entry_weight > r_limit;
    assign i_cfg.ready = 1'b1;

    // chain control
    assign w_ctrl.insert           = w_in_fire && w_is_insert && !w_heavy && !w_stat.full;
    assign w_ctrl.rotate           = (r_state == S_DUMP) && w_slot_free;
    assign w_ctrl.new_entry.id     = i_in.entry_id;
    assign w_ctrl.new_entry.weight = i_in.entry_weight;

    wpq_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_stat  (w_stat)
    );

    // sequencer state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_left       <= '0;
            r_limit      <= wpq_pkg::LIMIT_RESET;
            r_out_valid  <= 1'b0;
            r_out_status <= wpq_pkg::ST_INSERTED;
            r_out_id     <= '0;
            r_out_weight <= '0;
            r_out_last   <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_limit <= i_cfg.weight_limit;
            end
            if (w_ctrl.insert) begin
                r_count <= r_count + wpq_pkg::CNT_W'(1);
            end
            if (w_in_fire) begin
                r_out_valid  <= 1'b1;
                r_out_id     <= '0;
                r_out_weight <= '0;
                r_out_last   <= 1'b1;
                if (w_is_insert) begin
                    if (w_heavy) begin
                        r_out_status <= wpq_pkg::ST_REJECTED;
                    end else if (w_stat.full) begin
                        r_out_status <= wpq_pkg::ST_FULL;
                    end else begin
                        r_out_status <= wpq_pkg::ST_INSERTED;
                    end
                end else if (r_count == '0) begin
                    r_out_status <= wpq_pkg::ST_EMPTY;
                end else begin
                    // first entry goes out in the dump state
                    r_out_valid <= 1'b0;
                    r_state     <= S_DUMP;
                    r_left      <= r_count;
                end
            end else if (w_ctrl.rotate) begin
                r_out_valid  <= 1'b1;
                r_out_status <= wpq_pkg::ST_ENTRY;
                r_out_id     <= w_stat.head.id;
                r_out_weight <= w_stat.head.weight;
                r_out_last   <= (r_left == wpq_pkg::CNT_W'(1));
                r_left       <= r_left - wpq_pkg::CNT_W'(1);
                if (r_left == wpq_pkg::CNT_W'(1)) begin
                    r_state <= S_IDLE;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.out_id     = r_out_id;
    assign o_out.out_weight = r_out_weight;
    assign o_out.last       = r_out_last;

`ifndef NO_ASSERTIONS
    // no command is taken while a dump is running
    a_no_cmd_in_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> !i_in.ready)
        else $error("command accepted during dump");

    // entry count never exceeds the queue depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= wpq_pkg::CNT_W'(wpq_pkg::QUEUE_DEPTH))
        else $error("entry count above depth");

    // chain occupancy agrees with the entry count
    a_full_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.full == (r_count == wpq_pkg::CNT_W'(wpq_pkg::QUEUE_DEPTH)))
        else $error("chain occupancy and count disagree");

    // dump never emits more entries than are stored
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> (r_left != '0 && r_left <= r_count))
        else $error("dump counter out of range");
`endif

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// self-checking testbench of the weight priority queue core: directed table, random phases
`timescale 1ns / 1ps

module tb_top;

    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_ITEMS  = 76;
    localparam int SETTLE_CYCLES = 20;

    // one result item as the receiver sees it
    typedef struct packed {
        wpq_pkg::t_status             status;
        logic [wpq_pkg::ID_W-1:0]     id;
        logic [wpq_pkg::WEIGHT_W-1:0] weight;
        logic                         last;
    } t_result;

    // a table row is either a command item or a new weight limit
    typedef enum logic {
        ROW_ITEM  = 1'b0,
        ROW_LIMIT = 1'b1
    } t_row_kind;

    typedef struct packed {
        t_row_kind                    kind;
        wpq_pkg::t_opcode             op;
        logic [wpq_pkg::ID_W-1:0]     id;
        logic [wpq_pkg::WEIGHT_W-1:0] weight;
        logic                         fixed_exp;
        wpq_pkg::t_status             status;
    } t_row;

    localparam int N_ROWS = 25;

    // directed stimulus: weight column holds the new limit on limit rows
    localparam t_row DIRECTED_ROWS [N_ROWS] = '{
        '{ROW_ITEM,  wpq_pkg::OP_DUMP,   16'h0000, 8'd0,   1'b1, wpq_pkg::ST_EMPTY},
        '{ROW_ITEM,  wpq_pkg::OP_INSERT, 16'h1111, 8'd31,  1'b1, wpq_pkg::ST_REJECTED},
        '{ROW_ITEM,  wpq_pkg::OP_INSERT, 16'h0000, 8'd30,  1'b1, wpq_pkg::ST_INSERTED},
        '{ROW_ITEM,  wpq_pkg::OP_INSERT, 16'hFFFF, 8'd0,   1'b1, wpq_pkg::ST_INSERTED},
        '{ROW_ITEM,  wpq_pkg::OP_INSERT, 16'h0001, 8'd30,  1'b1, wpq_pkg::ST_INSERTED},
        '{ROW_ITEM,  wpq_pkg::OP_INSERT, 16'h8000, 8'd15,  1'b1, wpq_pkg::ST_INSERTED},
        '{ROW_ITEM,  wpq_pkg::OP_DUMP,   16'h0000, 8'd0,   1'b0, wpq_pkg::ST_ENTRY},
        '{ROW_LIMIT, wpq_pkg::OP_INSERT, 16'h0000, 8'd255, 1'b0, wpq_pkg::ST_INSERTED},
        '{ROW_ITEM,  wpq_pkg::OP_INSERT, 16'h7FFF, 8'd255, 1'b1, wpq_pkg::ST_INSERTED},
        '{ROW_ITEM,  wpq_pkg::OP_INSERT, 16'h00FF, 8'd0,   1'b1, wpq_pkg::ST_INSERTED},
        '{ROW_ITEM,  wpq_pkg::OP_INSERT, 16'hA5A5, 8'd128, 1'b1, wpq_pkg::ST_INSERTED},
        '{ROW_ITEM,  wpq_pkg::OP_INSERT, 16'h5A5A, 8'd15,  1'b1, wpq_pkg::ST_INSERTED},
        '{ROW_ITEM,  wpq_pkg::OP_INSERT, 16'h1234, 8'd254, 1'b1, wpq_pkg::ST_INSERTED},
        '{ROW_ITEM,  wpq_pkg::OP_INSERT, 16'hFEDC, 8'd1,   1'b1, wpq_pkg::ST_INSERTED},
        '{ROW_ITEM,  wpq_pkg::OP_INSERT, 16'h0F0F, 8'd255, 1'b1, wpq_pkg::ST_INSERTED},
        '{ROW_ITEM,  wpq_pkg::OP_INSERT, 16'hF0F0, 8'd128, 1'b1, wpq_pkg::ST_INSERTED},
        '{ROW_ITEM,  wpq_pkg::OP_INSERT, 16'h3C3C, 8'd64,  1'b1, wpq_pkg::ST_INSERTED},
        '{ROW_ITEM,  wpq_pkg::OP_INSERT, 16'hC3C3, 8'd30,  1'b1, wpq_pkg::ST_INSERTED},
        '{ROW_ITEM,  wpq_pkg::OP_INSERT, 16'h6666, 8'd200, 1'b1, wpq_pkg::ST_INSERTED},
        '{ROW_ITEM,  wpq_pkg::OP_INSERT, 16'h9999, 8'd2,   1'b1, wpq_pkg::ST_INSERTED},
        '{ROW_ITEM,  wpq_pkg::OP_INSERT, 16'h4444, 8'd100, 1'b1, wpq_pkg::ST_FULL},
        '{ROW_LIMIT, wpq_pkg::OP_INSERT, 16'h0000, 8'd0,   1'b0, wpq_pkg::ST_INSERTED},
        '{ROW_ITEM,  wpq_pkg::OP_INSERT, 16'h2222, 8'd1,   1'b1, wpq_pkg::ST_REJECTED},
        '{ROW_ITEM,  wpq_pkg::OP_INSERT, 16'h0000, 8'd0,   1'b1, wpq_pkg::ST_FULL},
        '{ROW_ITEM,  wpq_pkg::OP_DUMP,   16'hFFFF, 8'd255, 1'b0, wpq_pkg::ST_ENTRY}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    wpq_in_if  cmd_if ();
    wpq_out_if rsp_if ();
    wpq_cfg_if cfg_if ();

    weight_priority_queue_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // sorted queue mirror and its limit
    wpq_pkg::t_entry              sorted_entries [wpq_pkg::QUEUE_DEPTH];
    int                           sorted_count;
    logic [wpq_pkg::WEIGHT_W-1:0] accept_limit;

    t_result step_results[$];
    t_result awaited_results[$];

    int error_count;
    int results_seen;
    int send_idle_pct;
    int recv_idle_pct;

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // mismatch reporting
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // apply one command to the mirror, leaving its results in step_results
    function automatic void apply_command(input wpq_pkg::t_opcode op,
                                          input logic [wpq_pkg::ID_W-1:0] id,
                                          input logic [wpq_pkg::WEIGHT_W-1:0] weight);
        int pos;
        step_results.delete();
        if (op == wpq_pkg::OP_INSERT) begin
            if (weight > accept_limit) begin
                step_results.push_back('{wpq_pkg::ST_REJECTED, '0, '0, 1'b1});
            end else if (sorted_count >= wpq_pkg::QUEUE_DEPTH) begin
                step_results.push_back('{wpq_pkg::ST_FULL, '0, '0, 1'b1});
            end else begin
                // new entry goes behind every entry at least as heavy
                pos = 0;
                while (pos < sorted_count && sorted_entries[pos].weight >= weight) begin
                    pos++;
                end
                for (int i = sorted_count; i > pos; i--) begin
                    sorted_entries[i] = sorted_entries[i-1];
                end
                sorted_entries[pos] = '{id, weight};
                sorted_count++;
                step_results.push_back('{wpq_pkg::ST_INSERTED, '0, '0, 1'b1});
            end
        end else if (sorted_count == 0) begin
            step_results.push_back('{wpq_pkg::ST_EMPTY, '0, '0, 1'b1});
        end else begin
            for (int i = 0; i < sorted_count; i++) begin
                step_results.push_back('{wpq_pkg::ST_ENTRY, sorted_entries[i].id,
                                         sorted_entries[i].weight,
                                         logic'(i == sorted_count - 1)});
            end
        end
    endfunction

    // weights clustered round the limit, plus uniform ones
    function automatic logic [wpq_pkg::WEIGHT_W-1:0] pick_weight();
        logic [wpq_pkg::WEIGHT_W-1:0] w;
        case ($urandom_range(0, 3))
            0: w = accept_limit;
            1: w = accept_limit + 8'd1;
            2: w = accept_limit - 8'd1;
            default: w = wpq_pkg::WEIGHT_W'($urandom_range(0, 255));
        endcase
        return w;
    endfunction

    // present one command item after a random gap, wait for its acceptance
    task automatic send_command(input wpq_pkg::t_opcode op,
                                input logic [wpq_pkg::ID_W-1:0] id,
                                input logic [wpq_pkg::WEIGHT_W-1:0] weight,
                                input logic fixed_exp, input wpq_pkg::t_status fixed_status);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        apply_command(op, id, weight);
        if (fixed_exp) begin
            awaited_results.push_back('{fixed_status, '0, '0, 1'b1});
        end else begin
            foreach (step_results[k]) awaited_results.push_back(step_results[k]);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.opcode       <= op;
        cmd_if.entry_id     <= id;
        cmd_if.entry_weight <= weight;
        do @(posedge i_clk); while (!(cmd_if.valid && cmd_if.ready));
    endtask

    // hold the sender until every awaited result has arrived
    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    // write the limit while the block is idle
    task automatic write_limit(input logic [wpq_pkg::WEIGHT_W-1:0] value);
        drain_results();
        repeat (3) @(posedge i_clk);
        cfg_if.valid        <= 1'b1;
        cfg_if.weight_limit <= value;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        cfg_if.valid <= 1'b0;
        accept_limit = value;
    endtask

    // random commands under one idling pattern and one limit
    task automatic run_random_phase(input int send_pct, input int recv_pct,
                                    input logic [wpq_pkg::WEIGHT_W-1:0] limit);
        logic [wpq_pkg::ID_W-1:0] rid;
        write_limit(limit);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (RANDOM_ITEMS) begin
            if ($urandom_range(0, 29) == 0) drain_results();
            rid = wpq_pkg::ID_W'($urandom);
            send_command(wpq_pkg::t_opcode'($urandom_range(0, 1)), rid, pick_weight(),
                         1'b0, wpq_pkg::ST_INSERTED);
        end
    endtask

    // receiver stalls
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // result checking against the oldest awaited item
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("result %0d status %0d with nothing awaited",
                                          results_seen, rsp_if.status));
            end else begin
                want = awaited_results.pop_front();
                if (rsp_if.status !== want.status)
                    report_mismatch($sformatf("result %0d status got %0d expected %0d",
                                              results_seen, rsp_if.status, want.status));
                if (rsp_if.out_id !== want.id)
                    report_mismatch($sformatf("result %0d out_id got %h expected %h",
                                              results_seen, rsp_if.out_id, want.id));
                if (rsp_if.out_weight !== want.weight)
                    report_mismatch($sformatf("result %0d out_weight got %0d expected %0d",
                                              results_seen, rsp_if.out_weight, want.weight));
                if (rsp_if.last !== want.last)
                    report_mismatch($sformatf("result %0d last got %b expected %b",
                                              results_seen, rsp_if.last, want.last));
            end
            results_seen++;
        end
    end

    // watchdog on cycles with no handshake anywhere
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("weight_priority_queue_core regression: fail");
        $finish;
    end

    // stimulus sequence
    initial begin
        cmd_if.valid        <= 1'b0;
        cmd_if.opcode       <= wpq_pkg::OP_INSERT;
        cmd_if.entry_id     <= '0;
        cmd_if.entry_weight <= '0;
        cfg_if.valid        <= 1'b0;
        cfg_if.weight_limit <= '0;
        sorted_count  = 0;
        accept_limit  = wpq_pkg::LIMIT_RESET;
        error_count   = 0;
        results_seen  = 0;
        send_idle_pct = 16;
        recv_idle_pct = 57;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (DIRECTED_ROWS[r]) begin
            if (DIRECTED_ROWS[r].kind == ROW_LIMIT) begin
                write_limit(DIRECTED_ROWS[r].weight);
            end else begin
                send_command(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].id,
                             DIRECTED_ROWS[r].weight, DIRECTED_ROWS[r].fixed_exp,
                             DIRECTED_ROWS[r].status);
            end
        end

        // random phases: receiver sparse, then sender sparse, then full rate
        run_random_phase(16, 57, wpq_pkg::WEIGHT_W'($urandom_range(1, 254)));
        run_random_phase(57, 16, 8'd255);
        run_random_phase(0, 0, 8'd0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("weight_priority_queue_core regression: pass");
        end else begin
            $display("weight_priority_queue_core regression: fail");
        end
        $finish;
    end

endmodule
